FILE: rtl/core/stfr_pkg.sv
// Shared types, constants and the CRC step function for the SLIP TLV frame receiver.
package stfr_pkg;

    // SLIP framing bytes
    localparam logic [7:0] CODE_FEND  = 8'hC0;
    localparam logic [7:0] CODE_FESC  = 8'hDB;
    localparam logic [7:0] CODE_TFEND = 8'hDC;
    localparam logic [7:0] CODE_TFESC = 8'hDD;

    // Result kinds
    localparam logic [1:0] KIND_VALUE    = 2'd0;
    localparam logic [1:0] KIND_GOOD     = 2'd1;
    localparam logic [1:0] KIND_CRC_BAD  = 2'd2;
    localparam logic [1:0] KIND_ABORTED  = 2'd3;

    localparam logic [31:0] CRC_POLY_RESET = 32'hEDB88320;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Classified item passed from front to back
    typedef struct packed {
        logic       brk;    // frame break: END or bad escape
        logic [7:0] data;   // decoded data byte when brk is low
    } token_t;

    // Reflected bitwise CRC32 update over one byte
    function automatic logic [31:0] crc_byte(
        input logic [31:0] crc_in,
        input logic [7:0]  data,
        input logic [31:0] poly
    );
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ poly;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/stfr_front.sv
// Front end: removes SLIP byte stuffing and classifies each raw byte into a token.
module stfr_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         raw_byte,
    input  logic               q_full,
    output logic               push,
    output stfr_pkg::token_t   push_token
);

    logic esc_reg;
    logic esc_next;
    logic accept;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    // Classify the accepted byte
    always_comb
    begin
        esc_next        = esc_reg;
        push            = 1'b0;
        push_token.brk  = 1'b0;
        push_token.data = raw_byte;
        if (accept)
        begin
            if (raw_byte == stfr_pkg::CODE_FEND)
            begin
                esc_next       = 1'b0;
                push           = 1'b1;
                push_token.brk = 1'b1;
            end
            else if (esc_reg)
            begin
                esc_next = 1'b0;
                push     = 1'b1;
                if (raw_byte == stfr_pkg::CODE_TFEND)
                    push_token.data = stfr_pkg::CODE_FEND;
                else if (raw_byte == stfr_pkg::CODE_TFESC)
                    push_token.data = stfr_pkg::CODE_FESC;
                else
                    push_token.brk = 1'b1;
            end
            else if (raw_byte == stfr_pkg::CODE_FESC)
            begin
                esc_next = 1'b1;
            end
            else
            begin
                push = 1'b1;
            end
        end
    end

    // Hold escape state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            esc_reg <= 1'b0;
        else
            esc_reg <= esc_next;
    end

endmodule

FILE: rtl/core/stfr_queue.sv
// Short token queue between the front end and the frame parser.
module stfr_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  stfr_pkg::token_t   push_token,
    output logic               full,
    input  logic               pop,
    output logic               not_empty,
    output stfr_pkg::token_t   head
);

    stfr_pkg::token_t                    entry_reg [stfr_pkg::QUEUE_DEPTH];
    logic [stfr_pkg::QUEUE_PTR_W-1:0]    wr_ptr_reg;
    logic [stfr_pkg::QUEUE_PTR_W-1:0]    rd_ptr_reg;
    logic [stfr_pkg::QUEUE_CNT_W-1:0]    count_reg;
    logic [stfr_pkg::QUEUE_CNT_W-1:0]    count_next;

    assign full      = (count_reg == stfr_pkg::QUEUE_CNT_W'(stfr_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + stfr_pkg::QUEUE_CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - stfr_pkg::QUEUE_CNT_W'(1);
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // Store tokens
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_token;
    end

endmodule

FILE: rtl/core/stfr_back.sv
// Back end: TLV frame parser, running CRC32 and registered result output.
module stfr_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               tok_valid,
    input  stfr_pkg::token_t   tok,
    output logic               tok_pop,
    input  logic [31:0]        poly,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         kind,
    output logic [7:0]         value_byte,
    output logic [15:0]        value_index,
    output logic [7:0]         frame_tag,
    output logic [31:0]        message_id,
    output logic [15:0]        value_length,
    output logic [31:0]        crc_received,
    output logic [31:0]        crc_computed
);

    typedef enum logic [3:0] {
        PH_TAG   = 4'd0,
        PH_ID0   = 4'd1,
        PH_ID1   = 4'd2,
        PH_ID2   = 4'd3,
        PH_ID3   = 4'd4,
        PH_LEN0  = 4'd5,
        PH_LEN1  = 4'd6,
        PH_VALUE = 4'd7,
        PH_CRC0  = 4'd8,
        PH_CRC1  = 4'd9,
        PH_CRC2  = 4'd10,
        PH_CRC3  = 4'd11
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [31:0] crc_reg, crc_next;
    logic [7:0]  tag_reg, tag_next;
    logic [31:0] id_reg, id_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [31:0] trl_reg, trl_next;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  kind_reg, kind_next;
    logic [7:0]  vbyte_reg, vbyte_next;
    logic [15:0] vidx_reg, vidx_next;
    logic [31:0] crx_reg, crx_next;
    logic        emit;

    logic [31:0] crc_upd;
    logic [15:0] cnt_inc;
    logic [15:0] len_full;
    logic [31:0] trl_full;

    assign tok_pop  = tok_valid && (!out_valid_reg || !out_stall);
    assign crc_upd  = stfr_pkg::crc_byte(crc_reg, tok.data, poly);
    assign cnt_inc  = cnt_reg + 16'd1;
    assign len_full = {tok.data, len_reg[7:0]};
    assign trl_full = {tok.data, trl_reg[23:0]};

    // Parse one token
    always_comb
    begin
        phase_next = phase_reg;
        crc_next   = crc_reg;
        tag_next   = tag_reg;
        id_next    = id_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        trl_next   = trl_reg;
        emit       = 1'b0;
        kind_next  = stfr_pkg::KIND_VALUE;
        vbyte_next = 8'd0;
        vidx_next  = cnt_reg;
        crx_next   = 32'd0;
        if (tok_pop)
        begin
            if (tok.brk)
            begin
                // Drop the frame; report it if one was in progress
                emit       = (phase_reg != PH_TAG);
                kind_next  = stfr_pkg::KIND_ABORTED;
                phase_next = PH_TAG;
            end
            else
            begin
                unique case (phase_reg)
                    PH_TAG:
                    begin
                        crc_next   = stfr_pkg::crc_byte(32'd0, tok.data, poly);
                        tag_next   = tok.data;
                        id_next    = 32'd0;
                        len_next   = 16'd0;
                        cnt_next   = 16'd0;
                        trl_next   = 32'd0;
                        phase_next = PH_ID0;
                    end
                    PH_ID0:
                    begin
                        crc_next   = crc_upd;
                        id_next    = {id_reg[31:8], tok.data};
                        phase_next = PH_ID1;
                    end
                    PH_ID1:
                    begin
                        crc_next   = crc_upd;
                        id_next    = {id_reg[31:16], tok.data, id_reg[7:0]};
                        phase_next = PH_ID2;
                    end
                    PH_ID2:
                    begin
                        crc_next   = crc_upd;
                        id_next    = {id_reg[31:24], tok.data, id_reg[15:0]};
                        phase_next = PH_ID3;
                    end
                    PH_ID3:
                    begin
                        crc_next   = crc_upd;
                        id_next    = {tok.data, id_reg[23:0]};
                        phase_next = PH_LEN0;
                    end
                    PH_LEN0:
                    begin
                        crc_next   = crc_upd;
                        len_next   = {8'd0, tok.data};
                        phase_next = PH_LEN1;
                    end
                    PH_LEN1:
                    begin
                        crc_next   = crc_upd;
                        len_next   = len_full;
                        cnt_next   = 16'd0;
                        phase_next = (len_full == 16'd0) ? PH_CRC0 : PH_VALUE;
                    end
                    PH_VALUE:
                    begin
                        crc_next   = crc_upd;
                        cnt_next   = cnt_inc;
                        if (cnt_inc == len_reg)
                            phase_next = PH_CRC0;
                        emit       = 1'b1;
                        kind_next  = stfr_pkg::KIND_VALUE;
                        vbyte_next = tok.data;
                        vidx_next  = cnt_reg;
                    end
                    PH_CRC0:
                    begin
                        trl_next   = {trl_reg[31:8], tok.data};
                        phase_next = PH_CRC1;
                    end
                    PH_CRC1:
                    begin
                        trl_next   = {trl_reg[31:16], tok.data, trl_reg[7:0]};
                        phase_next = PH_CRC2;
                    end
                    PH_CRC2:
                    begin
                        trl_next   = {trl_reg[31:24], tok.data, trl_reg[15:0]};
                        phase_next = PH_CRC3;
                    end
                    PH_CRC3:
                    begin
                        trl_next   = trl_full;
                        phase_next = PH_TAG;
                        emit       = 1'b1;
                        kind_next  = (trl_full == crc_reg) ? stfr_pkg::KIND_GOOD
                                                           : stfr_pkg::KIND_CRC_BAD;
                        crx_next   = trl_full;
                    end
                    default:
                    begin
                        phase_next = PH_TAG;
                    end
                endcase
            end
        end
    end

    // Output valid: clear on transfer, set on a new result
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (emit)
            out_valid_next = 1'b1;
    end

    // Hold parser state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_TAG;
            crc_reg       <= 32'd0;
            tag_reg       <= 8'd0;
            id_reg        <= 32'd0;
            len_reg       <= 16'd0;
            cnt_reg       <= 16'd0;
            trl_reg       <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            crc_reg       <= crc_next;
            tag_reg       <= tag_next;
            id_reg        <= id_next;
            len_reg       <= len_next;
            cnt_reg       <= cnt_next;
            trl_reg       <= trl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg     <= kind_next;
            vbyte_reg    <= vbyte_next;
            vidx_reg     <= vidx_next;
            crx_reg      <= crx_next;
            frame_tag    <= tag_next;
            message_id   <= id_next;
            value_length <= len_next;
            crc_computed <= crc_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign value_byte   = vbyte_reg;
    assign value_index  = vidx_reg;
    assign crc_received = crx_reg;

endmodule

FILE: rtl/core/slip_tlv_frame_receiver_core.sv
// SLIP TLV frame receiver top level: front end, token queue and frame parser.
// Throughput: one raw byte per cycle, sustained while the output is not stalled.
// Path: a decoded token is written into the token queue, and its result is registered in the
// output register; a stalled output holds tokens in the queue.
// Reset: rst_n clears all control state at once; the CRC polynomial returns to 0xEDB88320.
// No clearing pass is needed; the block accepts input as soon as reset is released.
module slip_tlv_frame_receiver_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        crc_polynomial_we,
    input  logic [31:0] crc_polynomial_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  raw_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  value_byte,
    output logic [15:0] value_index,
    output logic [7:0]  frame_tag,
    output logic [31:0] message_id,
    output logic [15:0] value_length,
    output logic [31:0] crc_received,
    output logic [31:0] crc_computed
);

    logic [31:0]      poly_reg;
    logic             q_full;
    logic             q_push;
    stfr_pkg::token_t q_push_token;
    logic             q_pop;
    logic             q_not_empty;
    stfr_pkg::token_t q_head;

    // Hold the CRC polynomial
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            poly_reg <= stfr_pkg::CRC_POLY_RESET;
        else if (crc_polynomial_we)
            poly_reg <= crc_polynomial_wdata;
    end

    stfr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .raw_byte   (raw_byte),
        .q_full     (q_full),
        .push       (q_push),
        .push_token (q_push_token)
    );

    stfr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_token (q_push_token),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    stfr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .tok_valid    (q_not_empty),
        .tok          (q_head),
        .tok_pop      (q_pop),
        .poly         (poly_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .value_byte   (value_byte),
        .value_index  (value_index),
        .frame_tag    (frame_tag),
        .message_id   (message_id),
        .value_length (value_length),
        .crc_received (crc_received),
        .crc_computed (crc_computed)
    );

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the SLIP TLV frame receiver core.
module tb_top;

    localparam int unsigned TIMEOUT_CYCLES = 400000;
    localparam int unsigned SETTLE_CYCLES  = 4;
    localparam int unsigned PHASE_BYTES    = 330;
    localparam int unsigned REPORT_LIMIT   = 10;

    // Parser positions within a frame
    localparam logic [3:0] AT_TAG    = 4'd0;
    localparam logic [3:0] AT_ID0    = 4'd1;
    localparam logic [3:0] AT_ID3    = 4'd4;
    localparam logic [3:0] AT_LEN_LO = 4'd5;
    localparam logic [3:0] AT_LEN_HI = 4'd6;
    localparam logic [3:0] AT_VALUE  = 4'd7;
    localparam logic [3:0] AT_CRC0   = 4'd8;
    localparam logic [3:0] AT_CRC3   = 4'd11;

    // Ways a generated frame can end early
    typedef enum int { CUT_NONE, CUT_END, CUT_ESC_END, CUT_BAD_ESC } frame_cut_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  value_byte;
        logic [15:0] value_index;
        logic [7:0]  frame_tag;
        logic [31:0] message_id;
        logic [15:0] value_length;
        logic [31:0] crc_received;
        logic [31:0] crc_computed;
    } frame_result_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        crc_polynomial_we = 1'b0;
    logic [31:0] crc_polynomial_wdata = 32'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  raw_byte = 8'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  value_byte;
    logic [15:0] value_index;
    logic [7:0]  frame_tag;
    logic [31:0] message_id;
    logic [15:0] value_length;
    logic [31:0] crc_received;
    logic [31:0] crc_computed;

    // Parser state of the predictor
    logic        esc_armed = 1'b0;
    logic [3:0]  parse_at = AT_TAG;
    logic [31:0] crc_acc = 32'd0;
    logic [7:0]  tag_hold = 8'd0;
    logic [31:0] id_hold = 32'd0;
    logic [15:0] len_decl = 16'd0;
    logic [15:0] value_count = 16'd0;
    logic [31:0] trailer_hold = 32'd0;
    logic [31:0] poly_live = stfr_pkg::CRC_POLY_RESET;

    logic [7:0]    raw_stream[$];
    frame_result_t frame_results_due[$];

    bit          byte_taken = 1'b0;
    bit          result_taken = 1'b0;
    bit          send_calm = 1'b0;
    bit          recv_calm = 1'b0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned phase_count = 0;
    int unsigned error_count = 0;

    slip_tlv_frame_receiver_core dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .crc_polynomial_we    (crc_polynomial_we),
        .crc_polynomial_wdata (crc_polynomial_wdata),
        .in_valid             (in_valid),
        .in_stall             (in_stall),
        .raw_byte             (raw_byte),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .kind                 (kind),
        .value_byte           (value_byte),
        .value_index          (value_index),
        .frame_tag            (frame_tag),
        .message_id           (message_id),
        .value_length         (value_length),
        .crc_received         (crc_received),
        .crc_computed         (crc_computed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Reflected CRC32: feed data bits LSB first into the low end of the register
    function automatic logic [31:0] crc_step(
        input logic [31:0] acc,
        input logic [7:0]  data,
        input logic [31:0] poly
    );
        logic [31:0] r;
        logic        fb;
        r = acc;
        for (int k = 0; k < 8; k++)
        begin
            fb = r[0] ^ data[k];
            r = {1'b0, r[31:1]};
            if (fb)
                r = r ^ poly;
        end
        return r;
    endfunction

    task automatic push_result(
        input logic [1:0]  k,
        input logic [7:0]  vb,
        input logic [15:0] vi,
        input logic [31:0] crx
    );
        frame_result_t r;
        r.kind         = k;
        r.value_byte   = vb;
        r.value_index  = vi;
        r.frame_tag    = tag_hold;
        r.message_id   = id_hold;
        r.value_length = len_decl;
        r.crc_received = crx;
        r.crc_computed = crc_acc;
        frame_results_due.push_back(r);
    endtask

    // Drop the frame in progress; report the abort only if one was open
    task automatic break_frame();
        if (parse_at != AT_TAG)
            push_result(stfr_pkg::KIND_ABORTED, 8'd0, value_count, 32'd0);
        parse_at = AT_TAG;
    endtask

    // Predict the effect of one accepted raw byte
    task automatic deframe_byte(input logic [7:0] raw);
        logic [7:0]  data;
        int unsigned slot;
        data = raw;
        if (raw == stfr_pkg::CODE_FEND)
        begin
            esc_armed = 1'b0;
            break_frame();
            return;
        end
        if (esc_armed)
        begin
            esc_armed = 1'b0;
            if (raw == stfr_pkg::CODE_TFEND)
                data = stfr_pkg::CODE_FEND;
            else if (raw == stfr_pkg::CODE_TFESC)
                data = stfr_pkg::CODE_FESC;
            else
            begin
                break_frame();
                return;
            end
        end
        else if (raw == stfr_pkg::CODE_FESC)
        begin
            esc_armed = 1'b1;
            return;
        end

        if (parse_at == AT_TAG)
        begin
            crc_acc      = crc_step(32'd0, data, poly_live);
            tag_hold     = data;
            id_hold      = 32'd0;
            len_decl     = 16'd0;
            value_count  = 16'd0;
            trailer_hold = 32'd0;
            parse_at     = AT_ID0;
        end
        else if (parse_at <= AT_ID3)
        begin
            slot = 32'(parse_at - AT_ID0);
            crc_acc = crc_step(crc_acc, data, poly_live);
            id_hold[slot * 8 +: 8] = data;
            parse_at = parse_at + 4'd1;
        end
        else if (parse_at == AT_LEN_LO)
        begin
            crc_acc  = crc_step(crc_acc, data, poly_live);
            len_decl = {8'd0, data};
            parse_at = AT_LEN_HI;
        end
        else if (parse_at == AT_LEN_HI)
        begin
            crc_acc        = crc_step(crc_acc, data, poly_live);
            len_decl[15:8] = data;
            value_count    = 16'd0;
            parse_at       = (len_decl == 16'd0) ? AT_CRC0 : AT_VALUE;
        end
        else if (parse_at == AT_VALUE)
        begin
            slot        = 32'(value_count);
            crc_acc     = crc_step(crc_acc, data, poly_live);
            value_count = value_count + 16'd1;
            if (value_count == len_decl)
                parse_at = AT_CRC0;
            push_result(stfr_pkg::KIND_VALUE, data, 16'(slot), 32'd0);
        end
        else if (parse_at <= AT_CRC3)
        begin
            slot = 32'(parse_at - AT_CRC0);
            trailer_hold[slot * 8 +: 8] = data;
            if (parse_at == AT_CRC3)
            begin
                parse_at = AT_TAG;
                push_result((trailer_hold == crc_acc) ? stfr_pkg::KIND_GOOD
                                                      : stfr_pkg::KIND_CRC_BAD,
                            8'd0, value_count, trailer_hold);
            end
            else
                parse_at = parse_at + 4'd1;
        end
        else
            parse_at = AT_TAG;
    endtask

    task automatic show_result(input string label, input frame_result_t r);
        $display("  %s kind=%0d byte=%02h index=%0d tag=%02h id=%08h len=%0d crc_rx=%08h crc=%08h",
                 label, r.kind, r.value_byte, r.value_index, r.frame_tag, r.message_id,
                 r.value_length, r.crc_received, r.crc_computed);
    endtask

    // Check results, then predict from the byte taken at this edge
    always @(posedge clk)
    begin : monitor
        frame_result_t got;
        frame_result_t want;
        byte_taken   = rst_n && in_valid && !in_stall;
        result_taken = rst_n && out_valid && !out_stall;
        if (result_taken)
        begin
            got = '{kind, value_byte, value_index, frame_tag, message_id, value_length,
                    crc_received, crc_computed};
            if (frame_results_due.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                begin
                    $display("unexpected result at %0t", $time);
                    show_result("actual  ", got);
                end
            end
            else
            begin
                want = frame_results_due.pop_front();
                if (got.kind !== want.kind || got.value_byte !== want.value_byte ||
                    got.value_index !== want.value_index || got.frame_tag !== want.frame_tag ||
                    got.message_id !== want.message_id ||
                    got.value_length !== want.value_length ||
                    got.crc_received !== want.crc_received ||
                    got.crc_computed !== want.crc_computed)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                    begin
                        $display("result mismatch at %0t", $time);
                        show_result("expected", want);
                        show_result("actual  ", got);
                    end
                end
            end
        end
        if (byte_taken)
            deframe_byte(raw_byte);
    end

    // Present raw bytes; hold a stalled transfer, idle for a random gap, which may be none, between bytes
    always @(negedge clk)
    begin : sender
        if (rst_n && !(in_valid && !byte_taken))
        begin
            if (gap_left != 0)
            begin
                in_valid <= 1'b0;
                gap_left = gap_left - 1;
            end
            else if (raw_stream.size() != 0)
            begin
                raw_byte <= raw_stream.pop_front();
                in_valid <= 1'b1;
                if ($urandom_range(0, 39) == 0)
                    send_calm = !send_calm;
                gap_left = send_calm ? 0 : $urandom_range(0, 11);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Stall each result for a random time, which may be none
    always @(negedge clk)
    begin : receiver
        if (result_taken)
        begin
            if ($urandom_range(0, 39) == 0)
                recv_calm = !recv_calm;
            stall_left = recv_calm ? 0 : $urandom_range(0, 11);
        end
        if (rst_n && out_valid && stall_left != 0)
        begin
            out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end
        else
            out_stall <= 1'b0;
    end

    task automatic queue_raw(input logic [7:0] r);
        raw_stream.push_back(r);
        phase_count++;
    endtask

    // Stuff one decoded byte onto the link
    task automatic queue_data(input logic [7:0] d);
        if (d == stfr_pkg::CODE_FEND)
        begin
            queue_raw(stfr_pkg::CODE_FESC);
            queue_raw(stfr_pkg::CODE_TFEND);
        end
        else if (d == stfr_pkg::CODE_FESC)
        begin
            queue_raw(stfr_pkg::CODE_FESC);
            queue_raw(stfr_pkg::CODE_TFESC);
        end
        else
            queue_raw(d);
    endtask

    // Random byte with extra weight on the END and ESC codes
    function automatic logic [7:0] pick_data();
        case ($urandom_range(0, 9))
            0: return stfr_pkg::CODE_FEND;
            1: return stfr_pkg::CODE_FESC;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Build a frame, optionally spoil its trailer or cut it after keep decoded bytes
    task automatic send_frame(
        input logic [7:0]  tag,
        input logic [31:0] id,
        input logic [15:0] len,
        input bit          spoil,
        input frame_cut_t  cut,
        input int unsigned keep
    );
        logic [7:0]  body[$];
        logic [31:0] sum;
        logic [7:0]  esc_follow;
        int unsigned limit;
        limit = (cut == CUT_NONE) ? 32'hFFFF_FFFF : keep;
        body.push_back(tag);
        for (int k = 0; k < 4; k++)
            body.push_back(id[k * 8 +: 8]);
        body.push_back(len[7:0]);
        body.push_back(len[15:8]);
        for (int k = 0; k < int'(len) && body.size() < limit; k++)
            body.push_back(pick_data());
        if (body.size() == 32'd7 + 32'(len))
        begin
            sum = 32'd0;
            foreach (body[k])
                sum = crc_step(sum, body[k], poly_live);
            if (spoil)
                sum = sum ^ (32'd1 << $urandom_range(0, 31));
            for (int k = 0; k < 4; k++)
                body.push_back(sum[k * 8 +: 8]);
        end
        foreach (body[k])
            if (k < limit)
                queue_data(body[k]);
        case (cut)
            CUT_END:
                queue_raw(stfr_pkg::CODE_FEND);
            CUT_ESC_END:
            begin
                queue_raw(stfr_pkg::CODE_FESC);
                queue_raw(stfr_pkg::CODE_FEND);
            end
            CUT_BAD_ESC:
            begin
                do
                    esc_follow = ($urandom_range(0, 3) == 0) ? stfr_pkg::CODE_FESC
                                                              : 8'($urandom_range(0, 255));
                while (esc_follow == stfr_pkg::CODE_TFEND ||
                       esc_follow == stfr_pkg::CODE_TFESC ||
                       esc_follow == stfr_pkg::CODE_FEND);
                queue_raw(stfr_pkg::CODE_FESC);
                queue_raw(esc_follow);
            end
            default:
                ;
        endcase
    endtask

    // Mostly well-formed frames, some truncated, some noise
    task automatic queue_random_frame();
        logic [15:0] len;
        logic [31:0] id;
        int unsigned sel;
        int unsigned total;
        sel = $urandom_range(0, 99);
        case ($urandom_range(0, 19))
            0:             len = 16'($urandom_range(100, 300));
            1, 2, 3, 4, 5: len = 16'($urandom_range(7, 40));
            default:       len = 16'($urandom_range(0, 6));
        endcase
        case ($urandom_range(0, 7))
            0:       id = 32'd0;
            1:       id = 32'hFFFF_FFFF;
            default: id = $urandom;
        endcase
        total = 32'd11 + 32'(len);
        if ($urandom_range(0, 3) == 0)
            queue_raw(stfr_pkg::CODE_FEND);
        if (sel < 65)
            send_frame(pick_data(), id, len, $urandom_range(0, 4) == 0, CUT_NONE, 0);
        else if (sel < 80)
            send_frame(pick_data(), id, len, 1'b0,
                       ($urandom_range(0, 2) == 0) ? CUT_ESC_END : CUT_END,
                       $urandom_range(1, total - 1));
        else if (sel < 92)
            send_frame(pick_data(), id, len, 1'b0, CUT_BAD_ESC, $urandom_range(1, total - 1));
        else
        begin
            repeat ($urandom_range(1, 8))
                queue_raw(pick_data());
            queue_raw(stfr_pkg::CODE_FEND);
        end
    endtask

    // Wait until every byte is taken and every result has come, then let the pipe drain
    task automatic settle();
        while (raw_stream.size() != 0 || in_valid || frame_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_polynomial(input logic [31:0] value);
        @(negedge clk);
        crc_polynomial_we    <= 1'b1;
        crc_polynomial_wdata <= value;
        @(negedge clk);
        crc_polynomial_we <= 1'b0;
        poly_live = value;
    endtask

    initial
    begin : stimulus
        logic [31:0] poly_plan [5];
        poly_plan = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h82F6_3B78, 32'h0,
                      stfr_pkg::CRC_POLY_RESET};
        poly_plan[3] = $urandom;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Idle END and idle bad escape: no result
        queue_raw(stfr_pkg::CODE_FEND);
        queue_raw(stfr_pkg::CODE_FESC);
        queue_raw(8'h55);
        // Zero length, escaped tag, all-ones id
        send_frame(stfr_pkg::CODE_FEND, 32'hFFFF_FFFF, 16'd0, 1'b0, CUT_NONE, 0);
        // Largest declared length, then END right after ESC
        send_frame(stfr_pkg::CODE_FESC, 32'h0000_0000, 16'hFFFF, 1'b0, CUT_ESC_END, 7);
        // Short value with a spoiled trailer
        send_frame(8'h00, 32'h8000_0001, 16'd2, 1'b1, CUT_NONE, 0);
        // Double ESC inside a frame
        queue_data(8'hFF);
        queue_raw(stfr_pkg::CODE_FESC);
        queue_raw(stfr_pkg::CODE_FESC);

        for (int p = 0; p < 6; p++)
        begin
            if (p != 0)
            begin
                write_polynomial(poly_plan[p - 1]);
                phase_count = 0;
            end
            while (phase_count < PHASE_BYTES)
                queue_random_frame();
            settle();
        end

        if (error_count == 0 && frame_results_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_CYCLES * 10);
        $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: slip_tlv_frame_receiver_core.f
rtl/core/stfr_pkg.sv
rtl/core/stfr_front.sv
rtl/core/stfr_queue.sv
rtl/core/stfr_back.sv
rtl/core/slip_tlv_frame_receiver_core.sv
test/tb_top.sv
